// ===== rtl/ddodo_pkg.sv =====
// ddodo_pkg: shared constants, types and table functions for the odometry block
// no dependencies; every other file imports this package
package ddodo_pkg;

   localparam int SPEED_W       = 11;
   localparam int POS_W         = 32;
   localparam int HEAD_OUT_W    = 19;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 11'sd800;

   // wheel distance and turn factors, scaled by 2^40
   localparam int CS_W = 32;
   localparam logic signed [CS_W-1:0] DIST_K = 32'sd9059272;
   localparam logic signed [CS_W-1:0] TURN_K = 32'sd87108386;
   localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

   // cordic, angles in q30
   localparam int CORDIC_ITERS = 24;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam int ANG_W        = 35;
   localparam int Z_W          = 33;

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [ANG_W-1:0] FOLD_HI_Q30 = TWO_PI_Q30 - HALF_PI_Q30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_TURN,
      ST_ROT,
      ST_MULX,
      ST_MULZ,
      ST_DZ,
      ST_WRITE
   } ddodo_state_type;

   typedef enum logic [1:0] {
      MUL_DIST,
      MUL_TURN,
      MUL_SIN,
      MUL_COS
   } ddodo_mul_type;

   typedef struct packed {
      logic              load_in;
      logic              cordic_init;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              mul_en;
      ddodo_mul_type     mul_op;
      logic              du_load;
      logic              dth_load;
      logic              dx_load;
      logic              dz_load;
      logic              pose_write;
   } ddodo_cmd_type;

   function automatic logic [31:0] atan_q30(input logic [ITER_W-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:    v = 32'd843314856;
         5'd1:    v = 32'd497837829;
         5'd2:    v = 32'd263043836;
         5'd3:    v = 32'd133525158;
         5'd4:    v = 32'd67021686;
         5'd5:    v = 32'd33543515;
         5'd6:    v = 32'd16775850;
         5'd7:    v = 32'd8388437;
         5'd8:    v = 32'd4194282;
         5'd9:    v = 32'd2097149;
         5'd10:   v = 32'd1048575;
         5'd11:   v = 32'd524287;
         5'd12:   v = 32'd262143;
         5'd13:   v = 32'd131071;
         5'd14:   v = 32'd65535;
         5'd15:   v = 32'd32767;
         5'd16:   v = 32'd16383;
         5'd17:   v = 32'd8191;
         5'd18:   v = 32'd4095;
         5'd19:   v = 32'd2047;
         5'd20:   v = 32'd1023;
         5'd21:   v = 32'd511;
         5'd22:   v = 32'd255;
         5'd23:   v = 32'd127;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat_speed(
      input logic signed [SPEED_W-1:0] v
   );
      logic signed [SPEED_W-1:0] r;
      if (v > SPEED_MAX) begin
         r = SPEED_MAX;
      end else if (v < -SPEED_MAX) begin
         r = -SPEED_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/ddodo_if.sv =====
// ddodo_req_if, ddodo_rsp_if: valid/ready channels for wheel commands and pose words
// depends on ddodo_pkg for field widths
interface ddodo_req_if import ddodo_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] left_speed;
   logic signed [SPEED_W-1:0] right_speed;

   modport source (output valid, output left_speed, output right_speed, input ready);
   modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

interface ddodo_rsp_if import ddodo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_z;
   logic [HEAD_OUT_W-1:0]   heading;

   modport source (output valid, output pos_x, output pos_z, output heading, input ready);
   modport sink   (input valid, input pos_x, input pos_z, input heading, output ready);
endinterface

// ===== rtl/ddodo_ctrl.sv =====
// ddodo_ctrl: sequencer for one odometry step, cordic iteration count and result valid
// depends on ddodo_pkg
module ddodo_ctrl import ddodo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ddodo_cmd_type cmd
);

   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

   ddodo_state_type   state_ff, state_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_DIST;
         ST_DIST:  state_in = ST_TURN;
         ST_TURN:  state_in = ST_ROT;
         ST_ROT:   if (cnt_ff == LAST_ITER) state_in = ST_MULX;
         ST_MULX:  state_in = ST_MULZ;
         ST_MULZ:  state_in = ST_DZ;
         ST_DZ:    state_in = ST_WRITE;
         ST_WRITE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_op = MUL_DIST;
      cmd.iter   = cnt_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = !reset;
            cmd.load_in     = req_valid;
            cmd.cordic_init = req_valid;
         end
         ST_DIST: begin
            cmd.cordic_step = 1'b1;
            cmd.mul_en      = 1'b1;
            cmd.mul_op      = MUL_DIST;
         end
         ST_TURN: begin
            cmd.cordic_step = 1'b1;
            cmd.du_load     = 1'b1;
            cmd.mul_en      = 1'b1;
            cmd.mul_op      = MUL_TURN;
         end
         ST_ROT: begin
            cmd.cordic_step = 1'b1;
            cmd.dth_load    = 1'b1;
         end
         ST_MULX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_SIN;
         end
         ST_MULZ: begin
            cmd.dx_load = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_op  = MUL_COS;
         end
         ST_DZ: begin
            cmd.dz_load = 1'b1;
         end
         ST_WRITE: begin
            cmd.pose_write = out_free;
         end
         default: begin
            cmd.load_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cordic_init) begin
         cnt_in = '0;
      end else if (cmd.cordic_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pose_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ddodo_cordic.sv =====
// ddodo_cordic: iterative rotation-mode cordic, one micro-rotation per cycle while step is high
// depends on ddodo_pkg for the arctangent table and q30 constants
module ddodo_cordic import ddodo_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   init,
   input  logic                   step,
   input  logic [ITER_W-1:0]      iter,
   input  logic [FRAC_BITS+2:0]   heading,
   output logic signed [CS_W-1:0] cos_raw,
   output logic signed [CS_W-1:0] sin_raw,
   output logic                   neg
);

   logic signed [ANG_W-1:0] ang;
   logic signed [ANG_W-1:0] ang_fold;
   logic                    fold_neg;
   logic signed [CS_W-1:0]  x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]   z_ff, z_in, atan_v;
   logic                    neg_ff, neg_in;

   assign ang      = ANG_W'(heading) <<< (30 - FRAC_BITS);
   assign fold_neg = (ang > HALF_PI_Q30) && (ang < FOLD_HI_Q30);

   always_comb begin
      if (fold_neg) begin
         ang_fold = ang - PI_Q30;
      end else if (ang > PI_Q30) begin
         ang_fold = ang - TWO_PI_Q30;
      end else begin
         ang_fold = ang;
      end
   end

   assign xs     = x_ff >>> iter;
   assign ys     = y_ff >>> iter;
   assign atan_v = $signed(Z_W'(atan_q30(iter)));

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      neg_in = neg_ff;
      if (init) begin
         x_in   = CORDIC_GAIN;
         y_in   = '0;
         z_in   = ang_fold[Z_W-1:0];
         neg_in = fold_neg;
      end else if (step) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_raw = x_ff;
   assign sin_raw = y_ff;
   assign neg     = neg_ff;

endmodule

// ===== rtl/ddodo_dpath.sv =====
// ddodo_dpath: pose registers, shared multiplier, rounding and heading wrap
// depends on ddodo_pkg and ddodo_cordic
module ddodo_dpath import ddodo_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ddodo_cmd_type             cmd,
   input  logic signed [SPEED_W-1:0] left_speed,
   input  logic signed [SPEED_W-1:0] right_speed,
   output logic signed [POS_W-1:0]   pos_x,
   output logic signed [POS_W-1:0]   pos_z,
   output logic [HEAD_OUT_W-1:0]     heading
);

   localparam int H_W    = FRAC_BITS + 3;
   localparam int DU_W   = FRAC_BITS;
   localparam int DX_W   = DU_W + 1;
   localparam int MA_W   = FRAC_BITS + 1;
   localparam int P_W    = MA_W + CS_W;
   localparam int DU_SH  = 41 - FRAC_BITS;
   localparam int DTH_SH = 40 - FRAC_BITS;
   localparam int CS_SH  = 30;

   localparam logic signed [P_W-1:0] DU_HALF  = P_W'(64'sd1 <<< (DU_SH - 1));
   localparam logic signed [P_W-1:0] DTH_HALF = P_W'(64'sd1 <<< (DTH_SH - 1));
   localparam logic signed [P_W-1:0] CS_HALF  = P_W'(64'sd1 <<< (CS_SH - 1));
   localparam logic [63:0] TWO_PI_FX =
      (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic signed [H_W:0] TWO_PI_H = (H_W + 1)'(TWO_PI_FX);

   logic signed [SPEED_W-1:0] l_ff, r_ff;
   logic signed [SPEED_W:0]   sum_lr, dif_lr;
   logic signed [MA_W-1:0]    op_a;
   logic signed [CS_W-1:0]    op_b;
   logic signed [P_W-1:0]     mul_ff;
   logic signed [P_W-1:0]     du_rnd, dth_rnd, cs_rnd, cs_sh;
   logic signed [DU_W-1:0]    du_ff, dth_ff;
   logic signed [DX_W-1:0]    dx_ff, dz_ff;
   logic signed [H_W:0]       hsum_ff, hwrap;
   logic [POS_W-1:0]          x_ff, z_ff;
   logic [H_W-1:0]            heading_ff;
   logic [H_W+HEAD_OUT_W-1:0] head_ext;
   logic signed [CS_W-1:0]    cos_raw, sin_raw;
   logic                      cs_neg;

   ddodo_cordic #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cordic (
      .clock   (clock),
      .init    (cmd.cordic_init),
      .step    (cmd.cordic_step),
      .iter    (cmd.iter),
      .heading (heading_ff),
      .cos_raw (cos_raw),
      .sin_raw (sin_raw),
      .neg     (cs_neg)
   );

   assign sum_lr = (SPEED_W + 1)'(l_ff) + (SPEED_W + 1)'(r_ff);
   assign dif_lr = (SPEED_W + 1)'(r_ff) - (SPEED_W + 1)'(l_ff);

   always_comb begin
      unique case (cmd.mul_op)
         MUL_DIST: begin
            op_a = MA_W'(sum_lr);
            op_b = DIST_K;
         end
         MUL_TURN: begin
            op_a = MA_W'(dif_lr);
            op_b = TURN_K;
         end
         MUL_SIN: begin
            op_a = MA_W'(du_ff);
            op_b = sin_raw;
         end
         MUL_COS: begin
            op_a = MA_W'(du_ff);
            op_b = cos_raw;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // results are rounded toward plus infinity at the half, negated unless folded
   assign du_rnd  = (mul_ff + DU_HALF) >>> DU_SH;
   assign dth_rnd = (mul_ff + DTH_HALF) >>> DTH_SH;
   assign cs_rnd  = cs_neg ? (mul_ff + CS_HALF) : (CS_HALF - mul_ff);
   assign cs_sh   = cs_rnd >>> CS_SH;

   always_comb begin
      if (hsum_ff > TWO_PI_H) begin
         hwrap = hsum_ff - TWO_PI_H;
      end else if (hsum_ff < 0) begin
         hwrap = hsum_ff + TWO_PI_H;
      end else begin
         hwrap = hsum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         l_ff <= sat_speed(left_speed);
         r_ff <= sat_speed(right_speed);
      end
      if (cmd.mul_en) begin
         mul_ff <= op_a * op_b;
      end
      if (cmd.du_load) begin
         du_ff <= du_rnd[DU_W-1:0];
      end
      if (cmd.dth_load) begin
         dth_ff <= dth_rnd[DU_W-1:0];
      end
      if (cmd.dx_load) begin
         dx_ff <= cs_sh[DX_W-1:0];
      end
      if (cmd.dz_load) begin
         dz_ff   <= cs_sh[DX_W-1:0];
         hsum_ff <= (H_W + 1)'(heading_ff) + (H_W + 1)'(dth_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         z_ff       <= '0;
         heading_ff <= '0;
      end else if (cmd.pose_write) begin
         x_ff       <= x_ff + POS_W'(dx_ff);
         z_ff       <= z_ff + POS_W'(dz_ff);
         heading_ff <= hwrap[H_W-1:0];
      end
   end

   assign head_ext = (H_W + HEAD_OUT_W)'(heading_ff);
   assign pos_x    = x_ff;
   assign pos_z    = z_ff;
   assign heading  = head_ext[HEAD_OUT_W-1:0];

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// Differential-drive dead-reckoning odometry. Each accepted word carries one time step's
// left and right wheel speed commands (saturated to +/-800); the block advances the stored
// x/z position along the old heading and updates the heading, wrapped into 0 to 2 pi, and
// returns the new pose as one word. Positions and heading carry FRAC_BITS fraction bits.
// A word is accepted only while no step is in progress; after acceptance the cordic unit runs
// its 24 micro-rotations, one per cycle, while the shared multiplier takes the distance and
// turn passes, and the sine and cosine passes follow. A finished pose may wait in the output
// register while the next word is accepted, but that step cannot write its pose until the
// waiting one is taken, and a new word is taken only once the previous step has finished.
// depends on ddodo_pkg, ddodo_if, ddodo_ctrl, ddodo_dpath, ddodo_cordic
module differential_drive_odometry import ddodo_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ddodo_req_if.sink   req_chan,
   ddodo_rsp_if.source rsp_chan
);

   ddodo_cmd_type cmd;

   ddodo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   ddodo_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .left_speed  (req_chan.left_speed),
      .right_speed (req_chan.right_speed),
      .pos_x       (rsp_chan.pos_x),
      .pos_z       (rsp_chan.pos_z),
      .heading     (rsp_chan.heading)
   );

endmodule
